// ----- rtl/depq_pkg.sv -----
// ----------------------------------------------------------------------------
// depq_pkg
// Shared types and codes for the double-ended priority queue: operation and
// status codes, and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package depq_pkg;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP_HI = 2'd1,
        OP_POP_LO = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_UNUSED    = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    push_write;
        logic    scan_start;
        logic    scan_step;
        logic    shift_start;
        logic    shift_step;
        logic    finish;
        logic    popped;
        t_status res;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic full;
        logic empty;
        logic scan_last;
        logic no_shift;
        logic shift_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- rtl/depq_ctrl.sv -----
// ----------------------------------------------------------------------------
// depq_ctrl
// Sequencer for one request: decode, push write, priority scan, close-up
// shift and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module depq_ctrl
    import depq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_dp_status i_status,
    output logic            o_stall,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CHECK  = 8'b0000_0010,
        S_PUSH   = 8'b0000_0100,
        S_SCAN0  = 8'b0000_1000,
        S_SCAN   = 8'b0001_0000,
        S_SHIFT0 = 8'b0010_0000,
        S_SHIFT  = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } t_state;

    t_state  r_state, n_state;
    t_status r_res, n_res;
    logic    r_popped, n_popped;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_res    = r_res;
        n_popped = r_popped;
        o_cmd    = '0;
        o_cmd.res    = r_res;
        o_cmd.popped = r_popped;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_res    = ST_OK;
                n_popped = 1'b0;
                n_state  = S_FINISH;
                case (i_status.op) inside
                    OP_PUSH: begin
                        if (i_status.full) begin
                            n_res = ST_OVERFLOW;
                        end else begin
                            n_state = S_PUSH;
                        end
                    end
                    OP_POP_HI, OP_POP_LO: begin
                        if (i_status.empty) begin
                            n_res = ST_UNDERFLOW;
                        end else begin
                            n_popped = 1'b1;
                            n_state  = S_SCAN0;
                        end
                    end
                    default: begin
                        n_res = ST_OK;
                    end
                endcase
            end
            S_PUSH: begin
                o_cmd.push_write = 1'b1;
                n_state          = S_FINISH;
            end
            S_SCAN0: begin
                o_cmd.scan_start = 1'b1;
                n_state          = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_SHIFT0;
                end
            end
            S_SHIFT0: begin
                if (i_status.no_shift) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.shift_start = 1'b1;
                    n_state           = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_status.shift_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_res    <= ST_OK;
            r_popped <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_res    <= n_res;
            r_popped <= n_popped;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/depq_dp.sv -----
// ----------------------------------------------------------------------------
// depq_dp
// Entry store, occupancy count, scan and shift pointers, and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module depq_dp
    import depq_pkg::*;
#(
    parameter int DEPTH = 8
)(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    input  wire logic [1:0]         i_op,
    input  wire logic signed [31:0] i_push_data,
    input  wire logic signed [15:0] i_push_priority,
    input  wire logic               i_stall,
    output t_dp_status              o_status,
    output logic                    o_valid,
    output logic [1:0]              o_status_code,
    output logic signed [31:0]      o_popped_data,
    output logic signed [15:0]      o_popped_priority,
    output logic [3:0]              o_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    // entry store: one write and one registered read per cycle
    logic signed [31:0] mem_data [DEPTH];
    logic signed [15:0] mem_prio [DEPTH];

    t_op                r_op;
    logic signed [31:0] r_req_data;
    logic signed [15:0] r_req_prio;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_scan_idx;
    logic [CNT_W-1:0]   r_sh_idx;
    logic [CNT_W-1:0]   r_best_idx;
    logic signed [31:0] r_best_data;
    logic signed [15:0] r_best_prio;
    logic signed [31:0] r_rd_data;
    logic signed [15:0] r_rd_prio;

    logic               r_o_valid;
    t_status            r_o_status;
    logic signed [31:0] r_o_data;
    logic signed [15:0] r_o_prio;
    logic [3:0]         r_o_occ;

    logic [CNT_W-1:0]   cnt_m1;
    logic [CNT_W-1:0]   rd_ptr;
    logic [CNT_W-1:0]   wr_ptr;
    logic signed [31:0] wr_data;
    logic signed [15:0] wr_prio;
    logic               wr_en;
    logic               better;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W+3:0]   occ_ext;

    assign cnt_m1 = r_count - CNT_W'(1);

    assign o_status.op         = r_op;
    assign o_status.full       = (r_count == CNT_W'(DEPTH));
    assign o_status.empty      = (r_count == '0);
    assign o_status.scan_last  = (r_scan_idx == cnt_m1);
    assign o_status.no_shift   = (r_best_idx == cnt_m1);
    assign o_status.shift_last = (r_sh_idx == cnt_m1);
    assign o_status.out_free   = !r_o_valid || !i_stall;

    assign better = (r_op == OP_POP_HI) ? (r_rd_prio > r_best_prio)
                                        : (r_rd_prio < r_best_prio);

    // read and write port address selection
    always_comb begin
        rd_ptr  = r_scan_idx + CNT_W'(1);
        wr_en   = 1'b0;
        wr_ptr  = r_count;
        wr_data = r_req_data;
        wr_prio = r_req_prio;
        if (i_cmd.scan_start) begin
            rd_ptr = '0;
        end else if (i_cmd.shift_start) begin
            rd_ptr = r_best_idx + CNT_W'(1);
        end else if (i_cmd.shift_step) begin
            rd_ptr = r_sh_idx + CNT_W'(1);
        end
        if (i_cmd.push_write) begin
            wr_en = 1'b1;
        end else if (i_cmd.shift_step) begin
            wr_en   = 1'b1;
            wr_ptr  = r_sh_idx - CNT_W'(1);
            wr_data = r_rd_data;
            wr_prio = r_rd_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_data[wr_ptr[IDX_W-1:0]] <= wr_data;
            mem_prio[wr_ptr[IDX_W-1:0]] <= wr_prio;
        end
        r_rd_data <= mem_data[rd_ptr[IDX_W-1:0]];
        r_rd_prio <= mem_prio[rd_ptr[IDX_W-1:0]];
    end

    // request latch, scan and shift pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= t_op'(i_op);
            r_req_data <= i_push_data;
            r_req_prio <= i_push_priority;
        end
        if (i_cmd.scan_start) begin
            r_scan_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_idx <= r_scan_idx + CNT_W'(1);
            if (r_scan_idx == '0 || better) begin
                r_best_idx  <= r_scan_idx;
                r_best_data <= r_rd_data;
                r_best_prio <= r_rd_prio;
            end
        end
        if (i_cmd.shift_start) begin
            r_sh_idx <= r_best_idx + CNT_W'(1);
        end else if (i_cmd.shift_step) begin
            r_sh_idx <= r_sh_idx + CNT_W'(1);
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.push_write) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.finish && i_cmd.popped) begin
            n_count = cnt_m1;
        end
    end

    assign occ_ext = {4'b0000, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.finish) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_status <= i_cmd.res;
            r_o_data   <= i_cmd.popped ? r_best_data : 32'sd0;
            r_o_prio   <= i_cmd.popped ? r_best_prio : 16'sd0;
            r_o_occ    <= occ_ext[3:0];
        end
    end

    assign o_valid           = r_o_valid;
    assign o_status_code     = r_o_status;
    assign o_popped_data     = r_o_data;
    assign o_popped_priority = r_o_prio;
    assign o_occupancy       = r_o_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_write |-> !o_status.full)
        else $error("push written into a full store");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && i_cmd.popped) |-> !o_status.empty)
        else $error("removal from an empty store");

    a_shift_above_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift_step |-> (r_sh_idx > r_best_idx && r_sh_idx < r_count))
        else $error("close-up shift outside the live range");

endmodule

`default_nettype wire

// ----- rtl/double_ended_priority_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Bounded double-ended priority queue held as an unsorted array in arrival
// order.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_valid / o_stall): a request is taken on a rising edge
//   with i_valid high and o_stall low. i_op selects push, pop-highest or
//   pop-lowest; data and priority matter only for a push. Code 3 is a no-op.
//   Result channel (o_valid / i_stall): exactly one result per request, taken
//   on an edge with o_valid high and i_stall low. It carries the status (ok,
//   overflow, underflow), the removed pair (zero if none) and the occupancy
//   after the request, masked to four bits.
//   Flow: one request is worked on at a time. A pop scans every live entry
//   and then shifts each entry above the removed one down by one place:
//   the entry store has one read port, so the scan reads one entry a cycle
//   and the close-up shift moves one entry a cycle.
//   Ties go to the oldest entry. The result register parts the two sides, so
//   a new request is taken while a result still waits; a stalled result
//   holds, and the next one waits in its final step until the slot frees.
//   Reset (synchronous, active low) empties the queue and drops any result.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_priority_queue
    import depq_pkg::*;
#(
    parameter int DEPTH = 8
)(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_op,
    input  wire logic signed [31:0] i_push_data,
    input  wire logic signed [15:0] i_push_priority,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_popped_data,
    output logic signed [15:0]      o_popped_priority,
    output logic [3:0]              o_occupancy
);

    // command and status bundles between sequencer and datapath
    t_dp_cmd    cmd;
    t_dp_status dp_status;

    // sequencer: hold o_stall high from acceptance until the result is loaded
    depq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (dp_status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    // datapath: store, scan for the extreme, close up the gap, drive result
    depq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_op              (i_op),
        .i_push_data       (i_push_data),
        .i_push_priority   (i_push_priority),
        .i_stall           (i_stall),
        .o_status          (dp_status),
        .o_valid           (o_valid),
        .o_status_code     (o_status),
        .o_popped_data     (o_popped_data),
        .o_popped_priority (o_popped_priority),
        .o_occupancy       (o_occupancy)
    );

endmodule

`default_nettype wire
